### sv/wcr_pkg.sv
// Shared constants and types for the waveform column renderer.
`default_nettype none

package wcr_pkg;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 20;
    localparam int GEOM_BITS      = 11;
    localparam int COUNT_BITS     = 20;
    localparam int GAIN_BITS      = 16;
    localparam int POLICY_BITS    = 2;
    localparam int ROW_BITS       = 10;
    localparam int COL_BITS       = 10;

    localparam int MAX_COLUMNS = 1024;
    localparam int MAX_ROWS    = 1024;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_COLUMN_COUNT = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_ROW_COUNT    = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_BLOCK_SIZE   = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_GAIN         = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_LINE_POLICY  = 3'd4;

    localparam logic [POLICY_BITS-1:0] LINE_ON_TOP = 2'd0;
    localparam logic [POLICY_BITS-1:0] LINE_BELOW  = 2'd1;
    localparam logic [POLICY_BITS-1:0] LINE_NEVER  = 2'd2;

    localparam logic [GEOM_BITS-1:0]   RESET_COLUMN_COUNT = 11'd100;
    localparam logic [GEOM_BITS-1:0]   RESET_ROW_COUNT    = 11'd100;
    localparam logic [COUNT_BITS-1:0]  RESET_BLOCK_SIZE   = 20'd2400;
    localparam logic [GAIN_BITS-1:0]   RESET_GAIN         = 16'd256;
    localparam logic [POLICY_BITS-1:0] RESET_LINE_POLICY  = LINE_ON_TOP;

    typedef struct packed {
        logic                 start;
        logic [GAIN_BITS-1:0] gain;
        logic [ROW_BITS-1:0]  rows_m1;
    } map_req_t;

    typedef struct packed {
        logic                done;
        logic [ROW_BITS-1:0] row;
    } map_rsp_t;

endpackage

`default_nettype wire

### sv/wcr_row_mapper.sv
// Row mapper: scales one extreme by gain and maps it to a clamped row on one shared multiplier.
`default_nettype none

module wcr_row_mapper #(
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire wcr_pkg::map_req_t      req,
    input  wire logic [SAMPLE_BITS-1:0] value,
    output wcr_pkg::map_rsp_t           rsp
);

    localparam int A_W     = SAMPLE_BITS + wcr_pkg::GAIN_BITS + 1;
    localparam int B_W     = wcr_pkg::GAIN_BITS + 1;
    localparam int P_W     = A_W + B_W;
    localparam int N_W     = A_W + wcr_pkg::ROW_BITS + 1;
    localparam int SHIFT   = SAMPLE_BITS + 8;
    localparam int Q_W     = N_W - SHIFT;
    localparam logic [A_W-1:0] BIAS      = {{(A_W-1){1'b0}}, 1'b1} << (SAMPLE_BITS + 7);
    localparam logic [N_W-1:0] ROUND_ADD = {{(N_W-1){1'b0}}, 1'b1} << (SAMPLE_BITS + 7);

    typedef enum logic [2:0] {
        MS_IDLE  = 3'b001,
        MS_SCALE = 3'b010,
        MS_ROUND = 3'b100
    } map_state_t;

    map_state_t                   state_reg, state_next;
    logic [A_W-1:0]               prod_reg, prod_next;
    logic [N_W-1:0]               num_reg, num_next;
    logic [wcr_pkg::ROW_BITS-1:0] row_reg, row_next;
    logic                         done_reg, done_next;

    logic signed [A_W-1:0] mul_a;
    logic signed [B_W-1:0] mul_b;
    logic signed [P_W-1:0] mul_p;
    logic [N_W-1:0]        rounded;
    logic [Q_W-1:0]        quotient;
    logic [Q_W-1:0]        limit;

    always_comb
    begin
        if (state_reg == MS_SCALE)
        begin
            mul_a = $signed(prod_reg + BIAS);
            mul_b = $signed({{(B_W-wcr_pkg::ROW_BITS){1'b0}}, req.rows_m1});
        end
        else
        begin
            mul_a = $signed({{(A_W-SAMPLE_BITS){value[SAMPLE_BITS-1]}}, value});
            mul_b = $signed({1'b0, req.gain});
        end
        mul_p = mul_a * mul_b;
    end

    assign rounded  = num_reg + ROUND_ADD;
    assign quotient = rounded[N_W-1:SHIFT];
    assign limit    = {{(Q_W-wcr_pkg::ROW_BITS){1'b0}}, req.rows_m1};

    always_comb
    begin
        state_next = state_reg;
        prod_next  = prod_reg;
        num_next   = num_reg;
        row_next   = row_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            MS_IDLE:
            begin
                if (req.start)
                begin
                    prod_next  = mul_p[A_W-1:0];
                    state_next = MS_SCALE;
                end
            end
            MS_SCALE:
            begin
                num_next   = mul_p[N_W-1:0];
                state_next = MS_ROUND;
            end
            MS_ROUND:
            begin
                if (num_reg[N_W-1])
                begin
                    row_next = '0;
                end
                else if (quotient > limit)
                begin
                    row_next = req.rows_m1;
                end
                else
                begin
                    row_next = quotient[wcr_pkg::ROW_BITS-1:0];
                end
                done_next  = 1'b1;
                state_next = MS_IDLE;
            end
            default:
            begin
                state_next = MS_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MS_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        num_reg  <= num_next;
        row_reg  <= row_next;
    end

    assign rsp.done = done_reg;
    assign rsp.row  = row_reg;

endmodule

`default_nettype wire

### sv/waveform_column_renderer.sv
// Top level of the waveform column renderer: min/max folding, sequencing and column output.
`default_nettype none

// A sample beat that does not close a column is folded in the cycle it is taken, so such
// beats can arrive every cycle. The beat that closes a column raises sample_stall until its
// descriptor is loaded, so no other beat is taken meanwhile. The minimum and then the
// maximum pass through the shared row mapper: one multiplier used twice, then a round and
// clamp step, then the hand-back. The emit state then builds the descriptor. If the previous
// descriptor is still held by result_stall, the block waits for it before loading the new
// one. A write to any of the five defined config registers restarts the current column.

module waveform_column_renderer #(
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_write,
    input  wire logic [wcr_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire logic [wcr_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  wire logic                                sample_valid,
    output logic                                     sample_stall,
    input  wire logic [SAMPLE_BITS-1:0]              sample,
    output logic                                     result_valid,
    input  wire logic                                result_stall,
    output logic [wcr_pkg::COL_BITS-1:0]             column,
    output logic [wcr_pkg::ROW_BITS-1:0]             span_low,
    output logic [wcr_pkg::ROW_BITS-1:0]             span_high,
    output logic [wcr_pkg::ROW_BITS-1:0]             centre_row,
    output logic                                     line_shown
);

    localparam int GB = wcr_pkg::GEOM_BITS;
    localparam int RB = wcr_pkg::ROW_BITS;
    localparam int CB = wcr_pkg::COL_BITS;
    localparam logic [SAMPLE_BITS-1:0] SMP_MOST_POS = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] SMP_MOST_NEG = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_MAP_LO = 4'b0010,
        ST_MAP_HI = 4'b0100,
        ST_EMIT   = 4'b1000
    } state_t;

    state_t                              state_reg, state_next;
    logic [GB-1:0]                       column_count_reg, column_count_next;
    logic [GB-1:0]                       row_count_reg, row_count_next;
    logic [wcr_pkg::COUNT_BITS-1:0]      block_size_reg, block_size_next;
    logic [wcr_pkg::GAIN_BITS-1:0]       gain_reg, gain_next;
    logic [wcr_pkg::POLICY_BITS-1:0]     line_policy_reg, line_policy_next;
    logic [wcr_pkg::COUNT_BITS-1:0]      count_reg, count_next;
    logic signed [SAMPLE_BITS-1:0]       min_reg, min_next;
    logic signed [SAMPLE_BITS-1:0]       max_reg, max_next;
    logic [CB-1:0]                       pointer_reg, pointer_next;
    logic                                map_start_reg, map_start_next;
    logic                                valid_reg, valid_next;
    logic [RB-1:0]                       lo_reg, lo_next;
    logic [RB-1:0]                       hi_reg, hi_next;
    logic [CB-1:0]                       column_reg, column_next;
    logic [RB-1:0]                       span_low_reg, span_low_next;
    logic [RB-1:0]                       span_high_reg, span_high_next;
    logic [RB-1:0]                       centre_reg, centre_next;
    logic                                shown_reg, shown_next;

    logic [GB-1:0]                  rows_eff;
    logic [GB-1:0]                  cols_eff;
    logic [GB-1:0]                  rows_m1_full;
    logic [RB-1:0]                  rows_m1;
    logic [RB-1:0]                  centre;
    logic                           disabled;
    logic                           accept;
    logic                           out_free;
    logic signed [SAMPLE_BITS-1:0]  smp;
    logic signed [SAMPLE_BITS-1:0]  min_fold;
    logic signed [SAMPLE_BITS-1:0]  max_fold;
    logic [wcr_pkg::COUNT_BITS-1:0] count_inc;
    logic [RB-1:0]                  lo_adj;
    logic [RB-1:0]                  hi_adj;
    logic                           shown;
    logic [CB-1:0]                  ptr_cur;
    logic [GB-1:0]                  ptr_inc;
    logic [CB-1:0]                  ptr_adv;
    wcr_pkg::map_req_t              map_req;
    wcr_pkg::map_rsp_t              map_rsp;
    logic [SAMPLE_BITS-1:0]         map_value;

    assign rows_eff     = (row_count_reg > GB'(wcr_pkg::MAX_ROWS)) ?
                          GB'(wcr_pkg::MAX_ROWS) : row_count_reg;
    assign cols_eff     = (column_count_reg > GB'(wcr_pkg::MAX_COLUMNS)) ?
                          GB'(wcr_pkg::MAX_COLUMNS) : column_count_reg;
    assign rows_m1_full = rows_eff - GB'(1);
    assign rows_m1      = rows_m1_full[RB-1:0];
    assign centre       = rows_eff[GB-1:1];
    assign disabled     = (block_size_reg == '0) || (row_count_reg < GB'(2)) ||
                          (column_count_reg < GB'(2));

    assign sample_stall = (state_reg != ST_IDLE);
    assign accept       = sample_valid && !sample_stall;
    assign out_free     = !valid_reg || !result_stall;

    assign smp       = $signed(sample);
    assign min_fold  = (smp < min_reg) ? smp : min_reg;
    assign max_fold  = (smp > max_reg) ? smp : max_reg;
    assign count_inc = count_reg + wcr_pkg::COUNT_BITS'(1);

    assign map_req.start   = map_start_reg;
    assign map_req.gain    = gain_reg;
    assign map_req.rows_m1 = rows_m1;
    assign map_value       = (state_reg == ST_MAP_HI) ? max_reg : min_reg;

    wcr_row_mapper #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_mapper (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (map_req),
        .value (map_value),
        .rsp   (map_rsp)
    );

    always_comb
    begin
        lo_adj = lo_reg;
        hi_adj = hi_reg;
        if (lo_reg == hi_reg)
        begin
            if (hi_reg < rows_m1)
            begin
                hi_adj = hi_reg + RB'(1);
            end
            else
            begin
                lo_adj = lo_reg - RB'(1);
            end
        end
        case (line_policy_reg)
            wcr_pkg::LINE_ON_TOP: shown = 1'b1;
            wcr_pkg::LINE_BELOW:  shown = (centre < lo_adj) || (centre >= hi_adj);
            default:              shown = 1'b0;
        endcase
        ptr_cur = ({1'b0, pointer_reg} >= cols_eff) ? '0 : pointer_reg;
        ptr_inc = {1'b0, ptr_cur} + GB'(1);
        ptr_adv = (ptr_inc >= cols_eff) ? '0 : ptr_inc[CB-1:0];
    end

    always_comb
    begin
        state_next        = state_reg;
        column_count_next = column_count_reg;
        row_count_next    = row_count_reg;
        block_size_next   = block_size_reg;
        gain_next         = gain_reg;
        line_policy_next  = line_policy_reg;
        count_next        = count_reg;
        min_next          = min_reg;
        max_next          = max_reg;
        pointer_next      = pointer_reg;
        map_start_next    = 1'b0;
        valid_next        = valid_reg && result_stall;
        lo_next           = lo_reg;
        hi_next           = hi_reg;
        column_next       = column_reg;
        span_low_next     = span_low_reg;
        span_high_next    = span_high_reg;
        centre_next       = centre_reg;
        shown_next        = shown_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && !disabled)
                begin
                    min_next = min_fold;
                    max_next = max_fold;
                    if (count_inc >= block_size_reg)
                    begin
                        state_next     = ST_MAP_LO;
                        map_start_next = 1'b1;
                    end
                    else
                    begin
                        count_next = count_inc;
                    end
                end
            end
            ST_MAP_LO:
            begin
                if (map_rsp.done)
                begin
                    lo_next        = map_rsp.row;
                    state_next     = ST_MAP_HI;
                    map_start_next = 1'b1;
                end
            end
            ST_MAP_HI:
            begin
                if (map_rsp.done)
                begin
                    hi_next    = map_rsp.row;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    valid_next     = 1'b1;
                    column_next    = ptr_cur;
                    span_low_next  = lo_adj;
                    span_high_next = hi_adj;
                    centre_next    = centre;
                    shown_next     = shown;
                    pointer_next   = ptr_adv;
                    count_next     = '0;
                    min_next       = SMP_MOST_POS;
                    max_next       = SMP_MOST_NEG;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_write)
        begin
            unique case (cfg_index)
                wcr_pkg::CFG_COLUMN_COUNT: column_count_next = cfg_data[GB-1:0];
                wcr_pkg::CFG_ROW_COUNT:    row_count_next    = cfg_data[GB-1:0];
                wcr_pkg::CFG_BLOCK_SIZE:   block_size_next   =
                                               cfg_data[wcr_pkg::COUNT_BITS-1:0];
                wcr_pkg::CFG_GAIN:         gain_next         =
                                               cfg_data[wcr_pkg::GAIN_BITS-1:0];
                wcr_pkg::CFG_LINE_POLICY:  line_policy_next  =
                                               cfg_data[wcr_pkg::POLICY_BITS-1:0];
                default:                   ;
            endcase
            if (cfg_index <= wcr_pkg::CFG_LINE_POLICY)
            begin
                count_next = '0;
                min_next   = SMP_MOST_POS;
                max_next   = SMP_MOST_NEG;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            column_count_reg <= wcr_pkg::RESET_COLUMN_COUNT;
            row_count_reg    <= wcr_pkg::RESET_ROW_COUNT;
            block_size_reg   <= wcr_pkg::RESET_BLOCK_SIZE;
            gain_reg         <= wcr_pkg::RESET_GAIN;
            line_policy_reg  <= wcr_pkg::RESET_LINE_POLICY;
            count_reg        <= '0;
            min_reg          <= SMP_MOST_POS;
            max_reg          <= SMP_MOST_NEG;
            pointer_reg      <= '0;
            map_start_reg    <= 1'b0;
            valid_reg        <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            column_count_reg <= column_count_next;
            row_count_reg    <= row_count_next;
            block_size_reg   <= block_size_next;
            gain_reg         <= gain_next;
            line_policy_reg  <= line_policy_next;
            count_reg        <= count_next;
            min_reg          <= min_next;
            max_reg          <= max_next;
            pointer_reg      <= pointer_next;
            map_start_reg    <= map_start_next;
            valid_reg        <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        column_reg    <= column_next;
        span_low_reg  <= span_low_next;
        span_high_reg <= span_high_next;
        centre_reg    <= centre_next;
        shown_reg     <= shown_next;
    end

    assign result_valid = valid_reg;
    assign column       = column_reg;
    assign span_low     = span_low_reg;
    assign span_high    = span_high_reg;
    assign centre_row   = centre_reg;
    assign line_shown   = shown_reg;

endmodule

`default_nettype wire

### sv/wcr_checker.sv
// Port-level checks for the waveform column renderer and the bind that attaches them.
`default_nettype none

module wcr_checker #(
    parameter int SAMPLE_BITS = 16
) (
    input wire logic                                clk,
    input wire logic                                rst_n,
    input wire logic                                cfg_write,
    input wire logic [wcr_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input wire logic [wcr_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input wire logic                                sample_valid,
    input wire logic                                sample_stall,
    input wire logic [SAMPLE_BITS-1:0]              sample,
    input wire logic                                result_valid,
    input wire logic                                result_stall,
    input wire logic [wcr_pkg::COL_BITS-1:0]        column,
    input wire logic [wcr_pkg::ROW_BITS-1:0]        span_low,
    input wire logic [wcr_pkg::ROW_BITS-1:0]        span_high,
    input wire logic [wcr_pkg::ROW_BITS-1:0]        centre_row,
    input wire logic                                line_shown
);

    logic unused_inputs;
    assign unused_inputs = ^{cfg_write, cfg_index, cfg_data, sample_valid, sample, centre_row};

    // A stalled result beat keeps its valid and its whole payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid &&
        $stable(column) && $stable(span_low) && $stable(span_high) &&
        $stable(centre_row) && $stable(line_shown))
        else $error("stalled result beat changed");

    // The painted span is never empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> span_low < span_high)
        else $error("empty wave span");

    // A new result beat is only built while the sample side is held off.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(sample_stall))
        else $error("result produced while samples were being taken");

endmodule

bind waveform_column_renderer wcr_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_wcr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .column       (column),
    .span_low     (span_low),
    .span_high    (span_high),
    .centre_row   (centre_row),
    .line_shown   (line_shown)
);

`default_nettype wire

### tb/tb_waveform_column_renderer.sv
// Self-checking testbench for the waveform column renderer: directed and random sample traffic.
module tb_waveform_column_renderer;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SAMPLE_WIDTH = 16;
    localparam int ROW_SHIFT = 24;
    localparam longint ROW_HALF = 64'sd1 <<< (ROW_SHIFT - 1);
    localparam int SETTLE_CYCLES = 16;
    localparam logic [wcr_pkg::POLICY_BITS-1:0] LINE_UNUSED = 2'd3;
    localparam logic [wcr_pkg::CFG_INDEX_BITS-1:0] CFG_SPARE_LOW = 3'd5;
    localparam logic [wcr_pkg::CFG_INDEX_BITS-1:0] CFG_SPARE_HIGH = 3'd7;

    typedef struct packed {
        logic [wcr_pkg::COL_BITS-1:0] column;
        logic [wcr_pkg::ROW_BITS-1:0] span_low;
        logic [wcr_pkg::ROW_BITS-1:0] span_high;
        logic [wcr_pkg::ROW_BITS-1:0] centre_row;
        logic                         line_shown;
    } column_desc_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_write = 1'b0;
    logic [wcr_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [wcr_pkg::CFG_DATA_BITS-1:0] cfg_data = '0;
    logic sample_valid = 1'b0;
    logic sample_stall;
    logic [SAMPLE_WIDTH-1:0] sample = '0;
    logic result_valid;
    logic result_stall = 1'b0;
    logic [wcr_pkg::COL_BITS-1:0] column;
    logic [wcr_pkg::ROW_BITS-1:0] span_low;
    logic [wcr_pkg::ROW_BITS-1:0] span_high;
    logic [wcr_pkg::ROW_BITS-1:0] centre_row;
    logic line_shown;

    bit send_idle = 1'b1;
    bit recv_idle = 1'b1;
    int hold_left = 0;
    int mismatch_count = 0;

    logic [wcr_pkg::GEOM_BITS-1:0] cfg_cols;
    logic [wcr_pkg::GEOM_BITS-1:0] cfg_rows;
    logic [wcr_pkg::COUNT_BITS-1:0] cfg_block;
    logic [wcr_pkg::GAIN_BITS-1:0] cfg_gain;
    logic [wcr_pkg::POLICY_BITS-1:0] cfg_policy;
    logic [wcr_pkg::COUNT_BITS-1:0] fold_count;
    logic signed [SAMPLE_WIDTH-1:0] fold_min;
    logic signed [SAMPLE_WIDTH-1:0] fold_max;
    int unsigned next_column;

    column_desc_t pending_columns[$];
    column_desc_t next_desc;
    column_desc_t got_desc;
    column_desc_t want_desc;

    waveform_column_renderer #(
        .SAMPLE_BITS(SAMPLE_WIDTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .sample_valid(sample_valid),
        .sample_stall(sample_stall),
        .sample(sample),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .column(column),
        .span_low(span_low),
        .span_high(span_high),
        .centre_row(centre_row),
        .line_shown(line_shown)
    );

    always #4 clk = ~clk;

    function automatic void restart_fold();
        fold_count = '0;
        fold_min = 16'sh7FFF;
        fold_max = 16'sh8000;
    endfunction

    function automatic void reset_model();
        cfg_cols = wcr_pkg::RESET_COLUMN_COUNT;
        cfg_rows = wcr_pkg::RESET_ROW_COUNT;
        cfg_block = wcr_pkg::RESET_BLOCK_SIZE;
        cfg_gain = wcr_pkg::RESET_GAIN;
        cfg_policy = wcr_pkg::RESET_LINE_POLICY;
        next_column = 0;
        restart_fold();
    endfunction

    function automatic int unsigned row_of(input logic signed [SAMPLE_WIDTH-1:0] v,
                                           input int unsigned rows);
        longint prod;
        longint r;
        prod = (longint'(v) * longint'(cfg_gain) + ROW_HALF) * longint'(rows - 1);
        if (prod < 0)
            return 0;
        r = (prod + ROW_HALF) >>> ROW_SHIFT;
        if (r > longint'(rows - 1))
            r = rows - 1;
        return int'(r);
    endfunction

    function automatic bit fold_sample(input logic signed [SAMPLE_WIDTH-1:0] s,
                                       output column_desc_t d);
        int unsigned cols;
        int unsigned rows;
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        bit shown;
        if (cfg_block == 0 || cfg_rows < 2 || cfg_cols < 2)
            return 0;
        cols = (cfg_cols > wcr_pkg::MAX_COLUMNS) ? wcr_pkg::MAX_COLUMNS : cfg_cols;
        rows = (cfg_rows > wcr_pkg::MAX_ROWS) ? wcr_pkg::MAX_ROWS : cfg_rows;
        if (s < fold_min)
            fold_min = s;
        if (s > fold_max)
            fold_max = s;
        fold_count = fold_count + 1'b1;
        if (fold_count < cfg_block)
            return 0;
        lo = row_of(fold_min, rows);
        hi = row_of(fold_max, rows);
        if (lo == hi)
        begin
            if (hi < rows - 1)
                hi++;
            else
                lo--;
        end
        mid = rows / 2;
        case (cfg_policy)
            wcr_pkg::LINE_ON_TOP: shown = 1'b1;
            wcr_pkg::LINE_BELOW:  shown = (mid < lo || mid >= hi);
            default:              shown = 1'b0;
        endcase
        if (next_column >= cols)
            next_column = 0;
        d.column = next_column[wcr_pkg::COL_BITS-1:0];
        d.span_low = lo[wcr_pkg::ROW_BITS-1:0];
        d.span_high = hi[wcr_pkg::ROW_BITS-1:0];
        d.centre_row = mid[wcr_pkg::ROW_BITS-1:0];
        d.line_shown = shown;
        next_column++;
        if (next_column >= cols)
            next_column = 0;
        restart_fold();
        return 1;
    endfunction

    function automatic string desc_text(input column_desc_t d);
        return $sformatf("column %0d span %0d..%0d centre %0d line %0d",
                         d.column, d.span_low, d.span_high, d.centre_row, d.line_shown);
    endfunction

    function automatic logic [SAMPLE_WIDTH-1:0] rand_sample();
        case ($urandom_range(0, 9))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            3, 4: return 16'($urandom_range(0, 511)) - 16'd256;
            default: return 16'($urandom);
        endcase
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && sample_valid && !sample_stall)
        begin
            if (fold_sample(sample, next_desc))
                pending_columns.push_back(next_desc);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            got_desc = {column, span_low, span_high, centre_row, line_shown};
            if (pending_columns.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected descriptor: %s", desc_text(got_desc));
            end
            else
            begin
                want_desc = pending_columns.pop_front();
                if (got_desc !== want_desc)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("descriptor mismatch: expected %s, got %s",
                                 desc_text(want_desc), desc_text(got_desc));
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_stall <= 1'b0;
        else if (hold_left > 0)
        begin
            result_stall <= 1'b1;
            hold_left--;
        end
        else
            result_stall <= recv_idle && ($urandom_range(0, 99) < 16);
    end

    task automatic send_sample(input logic [SAMPLE_WIDTH-1:0] s);
        if (send_idle)
        begin
            while ($urandom_range(0, 99) < 16)
            begin
                sample_valid <= 1'b0;
                @(posedge clk);
            end
        end
        sample_valid <= 1'b1;
        sample <= s;
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
    endtask

    task automatic drain();
        sample_valid <= 1'b0;
        @(posedge clk);
        while (pending_columns.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [wcr_pkg::CFG_INDEX_BITS-1:0] idx,
                             input logic [wcr_pkg::CFG_DATA_BITS-1:0] data);
        bit known;
        known = 1'b1;
        drain();
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        case (idx)
            wcr_pkg::CFG_COLUMN_COUNT: cfg_cols = data[wcr_pkg::GEOM_BITS-1:0];
            wcr_pkg::CFG_ROW_COUNT:    cfg_rows = data[wcr_pkg::GEOM_BITS-1:0];
            wcr_pkg::CFG_BLOCK_SIZE:   cfg_block = data[wcr_pkg::COUNT_BITS-1:0];
            wcr_pkg::CFG_GAIN:         cfg_gain = data[wcr_pkg::GAIN_BITS-1:0];
            wcr_pkg::CFG_LINE_POLICY:  cfg_policy = data[wcr_pkg::POLICY_BITS-1:0];
            default:                   known = 1'b0;
        endcase
        if (known)
            restart_fold();
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    task automatic test_reset_values();
        write_reg(wcr_pkg::CFG_BLOCK_SIZE, 20'd1);
        send_sample(16'h7FFF);
        send_sample(16'h8000);
    endtask

    task automatic test_extremes();
        write_reg(wcr_pkg::CFG_ROW_COUNT, 20'd1024);
        write_reg(wcr_pkg::CFG_GAIN, 20'hFFFF);
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        write_reg(wcr_pkg::CFG_GAIN, 20'd0);
        send_sample(16'h5A5A);
        write_reg(wcr_pkg::CFG_ROW_COUNT, 20'd2);
        write_reg(wcr_pkg::CFG_GAIN, 20'd256);
        send_sample(16'h8000);
    endtask

    task automatic test_equal_rows();
        write_reg(wcr_pkg::CFG_ROW_COUNT, 20'd100);
        send_sample(16'h0000);
        send_sample(16'h7FFF);
    endtask

    task automatic test_line_policy();
        write_reg(wcr_pkg::CFG_LINE_POLICY, 20'(wcr_pkg::LINE_BELOW));
        send_sample(16'h0000);
        send_sample(16'd20000);
        write_reg(wcr_pkg::CFG_LINE_POLICY, 20'(wcr_pkg::LINE_NEVER));
        send_sample(16'hC000);
        write_reg(wcr_pkg::CFG_LINE_POLICY, 20'(LINE_UNUSED));
        send_sample(16'h4000);
    endtask

    task automatic test_geometry_limits();
        write_reg(wcr_pkg::CFG_COLUMN_COUNT, 20'd2047);
        write_reg(wcr_pkg::CFG_ROW_COUNT, 20'd2047);
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        write_reg(wcr_pkg::CFG_ROW_COUNT, 20'd1);
        send_sample(16'h1111);
        write_reg(wcr_pkg::CFG_ROW_COUNT, 20'd100);
        write_reg(wcr_pkg::CFG_COLUMN_COUNT, 20'd0);
        send_sample(16'h2222);
        write_reg(wcr_pkg::CFG_COLUMN_COUNT, 20'd100);
        write_reg(wcr_pkg::CFG_BLOCK_SIZE, 20'd0);
        send_sample(16'h3333);
    endtask

    task automatic test_pointer_wrap();
        write_reg(wcr_pkg::CFG_BLOCK_SIZE, 20'd1);
        write_reg(wcr_pkg::CFG_COLUMN_COUNT, 20'd3);
        repeat (3) send_sample(rand_sample());
    endtask

    task automatic test_block_restart();
        write_reg(wcr_pkg::CFG_BLOCK_SIZE, 20'd2);
        send_sample(16'h7000);
        write_reg(wcr_pkg::CFG_GAIN, 20'd512);
        send_sample(16'h9000);
        write_reg(CFG_SPARE_LOW, 20'hFFFFF);
        write_reg(CFG_SPARE_HIGH, 20'd0);
        send_sample(16'h0100);
        write_reg(wcr_pkg::CFG_BLOCK_SIZE, 20'hFFFFF);
        send_sample(16'h7FFF);
    endtask

    task automatic test_backpressure();
        write_reg(wcr_pkg::CFG_BLOCK_SIZE, 20'd1);
        write_reg(wcr_pkg::CFG_COLUMN_COUNT, 20'd16);
        write_reg(wcr_pkg::CFG_LINE_POLICY, 20'(wcr_pkg::LINE_ON_TOP));
        send_idle = 1'b0;
        recv_idle = 1'b0;
        hold_left = 300;
        repeat (24) send_sample(rand_sample());
        drain();
        send_idle = 1'b1;
        recv_idle = 1'b1;
        repeat (8) send_sample(rand_sample());
    endtask

    task automatic test_random_traffic();
        int unsigned cols;
        int unsigned rows;
        int unsigned blk;
        int unsigned amp;
        for (int phase = 0; phase < 8; phase++)
        begin
            case ($urandom_range(0, 3))
                0: cols = 2;
                1: cols = $urandom_range(3, 12);
                2: cols = 1024;
                default: cols = $urandom_range(2, 2047);
            endcase
            case ($urandom_range(0, 3))
                0: rows = 2;
                1: rows = $urandom_range(3, 1024);
                2: rows = 1024;
                default: rows = $urandom_range(1025, 2047);
            endcase
            blk = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
            case ($urandom_range(0, 4))
                0: amp = 256;
                1: amp = 0;
                2: amp = 65535;
                3: amp = $urandom_range(64, 2048);
                default: amp = $urandom_range(0, 65535);
            endcase
            write_reg(wcr_pkg::CFG_COLUMN_COUNT,
                      {9'($urandom), cols[wcr_pkg::GEOM_BITS-1:0]});
            write_reg(wcr_pkg::CFG_ROW_COUNT, {9'($urandom), rows[wcr_pkg::GEOM_BITS-1:0]});
            write_reg(wcr_pkg::CFG_BLOCK_SIZE, blk[wcr_pkg::COUNT_BITS-1:0]);
            write_reg(wcr_pkg::CFG_GAIN, {4'($urandom), amp[wcr_pkg::GAIN_BITS-1:0]});
            write_reg(wcr_pkg::CFG_LINE_POLICY, {18'($urandom), 2'($urandom)});
            send_idle = (phase != 3);
            recv_idle = (phase != 3);
            repeat (44) send_sample(rand_sample());
        end
        send_idle = 1'b1;
        recv_idle = 1'b1;
    endtask

    initial
    begin
        reset_model();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_values();
        test_extremes();
        test_equal_rows();
        test_line_policy();
        test_geometry_limits();
        test_pointer_wrap();
        test_block_restart();
        test_backpressure();
        test_random_traffic();
        drain();
        if (mismatch_count == 0 && pending_columns.size() == 0)
            $display("PASS waveform_column_renderer");
        else
            $display("FAIL waveform_column_renderer");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("FAIL waveform_column_renderer");
        $finish;
    end

endmodule

### files.f
sv/wcr_pkg.sv
sv/wcr_row_mapper.sv
sv/waveform_column_renderer.sv
sv/wcr_checker.sv
tb/tb_waveform_column_renderer.sv
